// File: sv/smc_pkg.sv
// Shared types and codes for the semaphore / mutex ceiling unit.
// No dependencies; used by smc_cell and semaphore_mutex_ceiling_unit.
package smc_pkg;

    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned TICKS_W  = 32;
    localparam int unsigned RES_CAP  = 8;
    localparam int unsigned NRES_W   = 4;

    localparam logic [1:0] REQ_TAKE = 2'd0;
    localparam logic [1:0] REQ_GIVE = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_KILL = 2'd3;

    localparam logic [1:0] KIND_BINARY    = 2'd0;
    localparam logic [1:0] KIND_COUNTING  = 2'd1;
    localparam logic [1:0] KIND_MUTEX     = 2'd2;
    localparam logic [1:0] KIND_RECURSIVE = 2'd3;

    localparam logic [1:0] REG_SEM_KIND      = 2'd0;
    localparam logic [1:0] REG_MAX_COUNT     = 2'd1;
    localparam logic [1:0] REG_INITIAL_COUNT = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TICKS_W-1:0] FOREVER   = '1;

    typedef enum logic [2:0] {
        OC_GRANTED        = 3'd0,
        OC_REFUSED        = 3'd1,
        OC_QUEUED         = 3'd2,
        OC_GIVEN          = 3'd3,
        OC_GIVE_REFUSED   = 3'd4,
        OC_WAITER_GRANTED = 3'd5,
        OC_WAITER_EXPIRED = 3'd6,
        OC_KILL_DONE      = 3'd7
    } outcome_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_COMPACT,
        CELL_CLEAR,
        CELL_TICK_ZERO,
        CELL_TICK_DEC
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_KILL,
        ST_KREL,
        ST_SEARCH,
        ST_GRANT,
        ST_COMPACT,
        ST_FINISH
    } state_t;

endpackage

// File: sv/smc_cell.sv
// One waiter slot of the queue chain: valid, task, priority and wait ticks.
// Depends on smc_pkg; instantiated in a row by semaphore_mutex_ceiling_unit.
module smc_cell #(
    parameter int unsigned TASK_ID_BITS = 8,
    parameter int unsigned PRIO_BITS    = 8,
    parameter int unsigned IDX_W        = 3,
    parameter int unsigned CELL_IDX     = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  smc_pkg::cell_op_t           op,
    input  logic [IDX_W-1:0]            sel,
    input  logic [TASK_ID_BITS-1:0]     new_task,
    input  logic [PRIO_BITS-1:0]        new_prio,
    input  logic [smc_pkg::TICKS_W-1:0] new_ticks,
    input  logic                        prev_valid,
    input  logic                        next_valid,
    input  logic [TASK_ID_BITS-1:0]     next_task,
    input  logic [PRIO_BITS-1:0]        next_prio,
    input  logic [smc_pkg::TICKS_W-1:0] next_ticks,
    output logic                        valid,
    output logic [TASK_ID_BITS-1:0]     task_id,
    output logic [PRIO_BITS-1:0]        prio,
    output logic [smc_pkg::TICKS_W-1:0] ticks
);

    logic                        valid_reg, valid_next;
    logic [TASK_ID_BITS-1:0]     task_reg, task_next;
    logic [PRIO_BITS-1:0]        prio_reg, prio_next;
    logic [smc_pkg::TICKS_W-1:0] ticks_reg, ticks_next;
    logic                        hit;

    assign hit = (sel == IDX_W'(CELL_IDX));

    always_comb
    begin
        valid_next = valid_reg;
        task_next  = task_reg;
        prio_next  = prio_reg;
        ticks_next = ticks_reg;
        unique case (op)
            smc_pkg::CELL_APPEND:
            begin
                if (!valid_reg && prev_valid)
                begin
                    valid_next = 1'b1;
                    task_next  = new_task;
                    prio_next  = new_prio;
                    ticks_next = new_ticks;
                end
            end
            smc_pkg::CELL_COMPACT:
            begin
                // pull the neighbor down into a hole, or hand this word down
                if (!valid_reg && next_valid)
                begin
                    valid_next = 1'b1;
                    task_next  = next_task;
                    prio_next  = next_prio;
                    ticks_next = next_ticks;
                end
                else if (valid_reg && !prev_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            smc_pkg::CELL_CLEAR:
            begin
                if (hit)
                begin
                    valid_next = 1'b0;
                end
            end
            smc_pkg::CELL_TICK_ZERO:
            begin
                if (hit)
                begin
                    ticks_next = '0;
                end
            end
            smc_pkg::CELL_TICK_DEC:
            begin
                if (hit)
                begin
                    ticks_next = ticks_reg - smc_pkg::TICKS_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg  <= task_next;
        prio_reg  <= prio_next;
        ticks_reg <= ticks_next;
    end

    assign valid   = valid_reg;
    assign task_id = task_reg;
    assign prio    = prio_reg;
    assign ticks   = ticks_reg;

endmodule

// File: sv/semaphore_mutex_ceiling_unit.sv
// Top level of the semaphore / mutex unit with priority ceiling.
// Depends on smc_pkg and smc_cell (row of waiter slots).
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+----------------------
//  request   | req_type task_id task_prio wait_ticks          | start & !busy
//  result    | outcome subject_task granted_prio count_now    | result_valid, 1 cycle
//            | last_result                                    |
//  config    | wr_index wr_data                               | wr_en
//
//  Path from the accepting edge to the next possible accept: take goes straight
//  to finish; give finishes, or wakes a waiter (search one slot per cycle, grant,
//  close the gap one slot per cycle); tick walks the row, then closes the gaps;
//  kill walks, closes the gaps, releases, then takes the wake path.
//  Each result word is held until the next word of the item is produced or the
//  item finishes, and shows the cycle after. Reset empties the row, count 1.
module semaphore_mutex_ceiling_unit #(
    parameter int unsigned MAX_WAITERS  = 8,
    parameter int unsigned TASK_ID_BITS = 8,
    parameter int unsigned PRIO_BITS    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  req_type,
    input  logic [TASK_ID_BITS-1:0]     task_id,
    input  logic [PRIO_BITS-1:0]        task_prio,
    input  logic [smc_pkg::TICKS_W-1:0] wait_ticks,
    input  logic                        wr_en,
    input  logic [1:0]                  wr_index,
    input  logic [smc_pkg::COUNT_W-1:0] wr_data,
    output logic                        result_valid,
    output logic [2:0]                  outcome,
    output logic [TASK_ID_BITS-1:0]     subject_task,
    output logic [PRIO_BITS-1:0]        granted_prio,
    output logic [smc_pkg::COUNT_W-1:0] count_now,
    output logic                        last_result
);

    localparam int unsigned IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_WAITERS + 1);
    localparam int unsigned CW    = smc_pkg::COUNT_W;

    // waiter row
    logic                        cv     [MAX_WAITERS];
    logic [TASK_ID_BITS-1:0]     ctask  [MAX_WAITERS];
    logic [PRIO_BITS-1:0]        cprio  [MAX_WAITERS];
    logic [smc_pkg::TICKS_W-1:0] cticks [MAX_WAITERS];
    smc_pkg::cell_op_t           cell_op;
    logic [IDX_W-1:0]            cell_sel;

    // control and object state
    smc_pkg::state_t         state_reg, state_next, then_reg, then_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [PRIO_BITS-1:0]    bestp_reg, bestp_next;
    logic [smc_pkg::NRES_W-1:0] nres_reg, nres_next;
    logic [TASK_ID_BITS-1:0] tid_reg, tid_next;
    logic [PRIO_BITS-1:0]    prio_reg, prio_next;
    logic                    owns_reg, owns_next;
    logic [1:0]              kind_reg;
    logic [CW-1:0]           max_reg;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           nest_reg, nest_next;
    logic                    ov_reg, ov_next;
    logic [TASK_ID_BITS-1:0] owner_reg, owner_next;
    logic [PRIO_BITS-1:0]    ceil_reg, ceil_next;

    // result staging
    logic                    pend_reg;
    logic [2:0]              pend_oc_reg;
    logic [TASK_ID_BITS-1:0] pend_task_reg;
    logic [PRIO_BITS-1:0]    pend_prio_reg;
    logic [CW-1:0]           pend_cnt_reg;
    logic                    rv_reg;
    logic [2:0]              oc_reg;
    logic [TASK_ID_BITS-1:0] st_reg;
    logic [PRIO_BITS-1:0]    gp_reg;
    logic [CW-1:0]           cn_reg;
    logic                    last_reg;

    logic                    emit_en;
    smc_pkg::outcome_t       emit_oc;
    logic [TASK_ID_BITS-1:0] emit_task;
    logic [PRIO_BITS-1:0]    emit_prio;
    logic                    g_do;
    logic [TASK_ID_BITS-1:0] g_task;
    logic [PRIO_BITS-1:0]    g_prio;
    logic [PRIO_BITS-1:0]    g_ceil;

    logic                    accept;
    logic                    is_mutex;
    logic                    owns_now;
    logic [IDX_W-1:0]        idx;
    logic                    walk_ok;
    logic                    holes;
    logic [CW-1:0]           cnt_inc;

    assign accept   = start && (state_reg == smc_pkg::ST_IDLE);
    assign busy     = (state_reg != smc_pkg::ST_IDLE);
    assign is_mutex = kind_reg[1];
    assign owns_now = is_mutex && ov_reg && (owner_reg == task_id);
    assign idx      = i_reg[IDX_W-1:0];
    assign walk_ok  = (i_reg < CNT_W'(MAX_WAITERS)) && cv[idx];
    assign cnt_inc  = (cnt_reg != smc_pkg::COUNT_MAX) ? cnt_reg + CW'(1) : cnt_reg;
    assign g_ceil   = (g_prio < ceil_reg) ? g_prio : ceil_reg;

    always_comb
    begin
        holes = 1'b0;
        for (int k = 0; k + 1 < MAX_WAITERS; k++)
        begin
            holes = holes | (!cv[k] && cv[k+1]);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WAITERS; gi++)
        begin : g_row
            logic                        pv;
            logic                        nv;
            logic [TASK_ID_BITS-1:0]     nt;
            logic [PRIO_BITS-1:0]        np;
            logic [smc_pkg::TICKS_W-1:0] nk;
            if (gi == 0)
            begin : g_head
                assign pv = 1'b1;
            end
            else
            begin : g_body
                assign pv = cv[gi-1];
            end
            if (gi == MAX_WAITERS - 1)
            begin : g_tail
                assign nv = 1'b0;
                assign nt = '0;
                assign np = '0;
                assign nk = '0;
            end
            else
            begin : g_link
                assign nv = cv[gi+1];
                assign nt = ctask[gi+1];
                assign np = cprio[gi+1];
                assign nk = cticks[gi+1];
            end
            smc_cell #(
                .TASK_ID_BITS (TASK_ID_BITS),
                .PRIO_BITS    (PRIO_BITS),
                .IDX_W        (IDX_W),
                .CELL_IDX     (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (cell_op),
                .sel        (cell_sel),
                .new_task   (task_id),
                .new_prio   (task_prio),
                .new_ticks  (wait_ticks),
                .prev_valid (pv),
                .next_valid (nv),
                .next_task  (nt),
                .next_prio  (np),
                .next_ticks (nk),
                .valid      (cv[gi]),
                .task_id    (ctask[gi]),
                .prio       (cprio[gi]),
                .ticks      (cticks[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        smc_pkg::REQ_TICK: state_next = smc_pkg::ST_TICK;
                        smc_pkg::REQ_KILL: state_next = smc_pkg::ST_KILL;
                        smc_pkg::REQ_GIVE:
                        begin
                            if (emit_oc == smc_pkg::OC_GIVEN && cnt_next != '0 && cv[0]
                                && !(kind_reg == smc_pkg::KIND_RECURSIVE && owns_now
                                     && nest_reg > CW'(1)))
                            begin
                                state_next = smc_pkg::ST_SEARCH;
                            end
                            else
                            begin
                                state_next = smc_pkg::ST_FINISH;
                            end
                        end
                        default: state_next = smc_pkg::ST_FINISH;
                    endcase
                end
            end
            smc_pkg::ST_TICK:
            begin
                if (!walk_ok)
                begin
                    state_next = smc_pkg::ST_COMPACT;
                end
            end
            smc_pkg::ST_KILL:
            begin
                if (!walk_ok)
                begin
                    state_next = smc_pkg::ST_COMPACT;
                end
            end
            smc_pkg::ST_KREL:
            begin
                if (owns_reg && cnt_next != '0 && cv[0])
                begin
                    state_next = smc_pkg::ST_SEARCH;
                end
                else
                begin
                    state_next = smc_pkg::ST_FINISH;
                end
            end
            smc_pkg::ST_SEARCH:
            begin
                if (!walk_ok)
                begin
                    state_next = smc_pkg::ST_GRANT;
                end
            end
            smc_pkg::ST_GRANT:   state_next = smc_pkg::ST_COMPACT;
            smc_pkg::ST_COMPACT:
            begin
                if (!holes)
                begin
                    state_next = then_reg;
                end
            end
            smc_pkg::ST_FINISH:  state_next = smc_pkg::ST_IDLE;
            default:             state_next = smc_pkg::ST_IDLE;
        endcase
    end

    // datapath and row commands
    always_comb
    begin
        then_next  = then_reg;
        i_next     = i_reg;
        best_next  = best_reg;
        bestp_next = bestp_reg;
        nres_next  = nres_reg;
        tid_next   = tid_reg;
        prio_next  = prio_reg;
        owns_next  = owns_reg;
        cnt_next   = cnt_reg;
        nest_next  = nest_reg;
        ov_next    = ov_reg;
        owner_next = owner_reg;
        ceil_next  = ceil_reg;
        emit_en    = 1'b0;
        emit_oc    = smc_pkg::OC_GRANTED;
        emit_task  = tid_reg;
        emit_prio  = prio_reg;
        g_do       = 1'b0;
        g_task     = task_id;
        g_prio     = task_prio;
        cell_op    = smc_pkg::CELL_HOLD;
        cell_sel   = idx;

        unique case (state_reg)
            smc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    tid_next   = task_id;
                    prio_next  = task_prio;
                    owns_next  = owns_now;
                    i_next     = '0;
                    nres_next  = '0;
                    best_next  = '0;
                    bestp_next = cprio[0];
                    emit_task  = task_id;
                    emit_prio  = task_prio;
                    unique case (req_type)
                        smc_pkg::REQ_TAKE:
                        begin
                            emit_en = 1'b1;
                            if (owns_now)
                            begin
                                if (kind_reg == smc_pkg::KIND_RECURSIVE)
                                begin
                                    if (nest_reg != smc_pkg::COUNT_MAX)
                                    begin
                                        nest_next = nest_reg + CW'(1);
                                    end
                                    emit_oc   = smc_pkg::OC_GRANTED;
                                    emit_prio = ceil_reg;
                                end
                                else
                                begin
                                    emit_oc = smc_pkg::OC_REFUSED;
                                end
                            end
                            else if (cnt_reg != '0)
                            begin
                                g_do    = 1'b1;
                                emit_oc = smc_pkg::OC_GRANTED;
                            end
                            else if (wait_ticks != '0 && !cv[MAX_WAITERS-1])
                            begin
                                cell_op = smc_pkg::CELL_APPEND;
                                emit_oc = smc_pkg::OC_QUEUED;
                            end
                            else
                            begin
                                emit_oc = smc_pkg::OC_REFUSED;
                            end
                        end
                        smc_pkg::REQ_GIVE:
                        begin
                            emit_en = 1'b1;
                            i_next  = CNT_W'(1);
                            if (is_mutex)
                            begin
                                if (owns_now)
                                begin
                                    emit_oc = smc_pkg::OC_GIVEN;
                                    if (kind_reg == smc_pkg::KIND_RECURSIVE
                                        && nest_reg > CW'(1))
                                    begin
                                        nest_next = nest_reg - CW'(1);
                                    end
                                    else
                                    begin
                                        ov_next   = 1'b0;
                                        nest_next = '0;
                                        cnt_next  = cnt_inc;
                                    end
                                end
                                else
                                begin
                                    emit_oc = smc_pkg::OC_GIVE_REFUSED;
                                end
                            end
                            else if (cnt_reg >= max_reg)
                            begin
                                emit_oc = smc_pkg::OC_GIVE_REFUSED;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CW'(1);
                                emit_oc  = smc_pkg::OC_GIVEN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            smc_pkg::ST_TICK:
            begin
                if (walk_ok)
                begin
                    i_next = i_reg + CNT_W'(1);
                    if (cticks[idx] != smc_pkg::FOREVER
                        && cticks[idx] <= smc_pkg::TICKS_W'(1))
                    begin
                        if (nres_reg < smc_pkg::NRES_W'(smc_pkg::RES_CAP))
                        begin
                            cell_op   = smc_pkg::CELL_CLEAR;
                            nres_next = nres_reg + smc_pkg::NRES_W'(1);
                            emit_en   = 1'b1;
                            emit_oc   = smc_pkg::OC_WAITER_EXPIRED;
                            emit_task = ctask[idx];
                            emit_prio = cprio[idx];
                        end
                        else
                        begin
                            cell_op = smc_pkg::CELL_TICK_ZERO;
                        end
                    end
                    else if (cticks[idx] != smc_pkg::FOREVER)
                    begin
                        cell_op = smc_pkg::CELL_TICK_DEC;
                    end
                end
                else
                begin
                    then_next = smc_pkg::ST_FINISH;
                end
            end
            smc_pkg::ST_KILL:
            begin
                if (walk_ok)
                begin
                    i_next = i_reg + CNT_W'(1);
                    if (ctask[idx] == tid_reg)
                    begin
                        cell_op = smc_pkg::CELL_CLEAR;
                    end
                end
                else
                begin
                    then_next = smc_pkg::ST_KREL;
                end
            end
            smc_pkg::ST_KREL:
            begin
                if (owns_reg)
                begin
                    ov_next   = 1'b0;
                    nest_next = '0;
                    cnt_next  = cnt_inc;
                end
                emit_en    = 1'b1;
                emit_oc    = smc_pkg::OC_KILL_DONE;
                i_next     = CNT_W'(1);
                best_next  = '0;
                bestp_next = cprio[0];
            end
            smc_pkg::ST_SEARCH:
            begin
                if (walk_ok)
                begin
                    i_next = i_reg + CNT_W'(1);
                    if (cprio[idx] < bestp_reg)
                    begin
                        best_next  = idx;
                        bestp_next = cprio[idx];
                    end
                end
            end
            smc_pkg::ST_GRANT:
            begin
                cell_op   = smc_pkg::CELL_CLEAR;
                cell_sel  = best_reg;
                g_do      = 1'b1;
                g_task    = ctask[best_reg];
                g_prio    = cprio[best_reg];
                emit_en   = 1'b1;
                emit_oc   = smc_pkg::OC_WAITER_GRANTED;
                emit_task = g_task;
                then_next = smc_pkg::ST_FINISH;
            end
            smc_pkg::ST_COMPACT:
            begin
                cell_op = smc_pkg::CELL_COMPACT;
            end
            default:
            begin
            end
        endcase

        if (g_do)
        begin
            emit_prio = g_prio;
            if (is_mutex)
            begin
                ceil_next  = g_ceil;
                emit_prio  = g_ceil;
                ov_next    = 1'b1;
                owner_next = g_task;
                if (kind_reg == smc_pkg::KIND_RECURSIVE)
                begin
                    nest_next = CW'(1);
                end
            end
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smc_pkg::ST_IDLE;
            then_reg  <= smc_pkg::ST_FINISH;
            i_reg     <= '0;
            best_reg  <= '0;
            nres_reg  <= '0;
            owns_reg  <= 1'b0;
            kind_reg  <= smc_pkg::KIND_BINARY;
            max_reg   <= CW'(1);
            cnt_reg   <= CW'(1);
            nest_reg  <= '0;
            ov_reg    <= 1'b0;
            owner_reg <= '0;
            ceil_reg  <= '1;
            pend_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            then_reg  <= then_next;
            i_reg     <= i_next;
            best_reg  <= best_next;
            nres_reg  <= nres_next;
            owns_reg  <= owns_next;
            nest_reg  <= nest_next;
            ov_reg    <= ov_next;
            owner_reg <= owner_next;
            ceil_reg  <= ceil_next;
            if (wr_en && wr_index == smc_pkg::REG_INITIAL_COUNT)
            begin
                cnt_reg <= (is_mutex && wr_data > CW'(1)) ? CW'(1) : wr_data;
            end
            else
            begin
                cnt_reg <= cnt_next;
            end
            if (wr_en)
            begin
                unique case (wr_index)
                    smc_pkg::REG_SEM_KIND:  kind_reg <= wr_data[1:0];
                    smc_pkg::REG_MAX_COUNT: max_reg  <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
            // hold each result until the next one or the finish so the final one can be marked
            if (emit_en)
            begin
                pend_reg <= 1'b1;
                rv_reg   <= pend_reg;
                last_reg <= 1'b0;
            end
            else if (state_reg == smc_pkg::ST_FINISH)
            begin
                pend_reg <= 1'b0;
                rv_reg   <= pend_reg;
                last_reg <= 1'b1;
            end
            else
            begin
                rv_reg   <= 1'b0;
                last_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg   <= tid_next;
        prio_reg  <= prio_next;
        bestp_reg <= bestp_next;
        if (emit_en || state_reg == smc_pkg::ST_FINISH)
        begin
            oc_reg <= pend_oc_reg;
            st_reg <= pend_task_reg;
            gp_reg <= pend_prio_reg;
            cn_reg <= pend_cnt_reg;
        end
        if (emit_en)
        begin
            pend_oc_reg   <= emit_oc;
            pend_task_reg <= emit_task;
            pend_prio_reg <= emit_prio;
            pend_cnt_reg  <= cnt_next;
        end
    end

    assign result_valid = rv_reg;
    assign outcome      = oc_reg;
    assign subject_task = st_reg;
    assign granted_prio = gp_reg;
    assign count_now    = cn_reg;
    assign last_result  = last_reg;

endmodule

// File: bench/smc_checker.sv
`timescale 1ns / 100ps
// Checker for the semaphore / mutex ceiling unit: watches requests, register writes
// and results, predicts every result word and compares it. Depends on smc_pkg.
module smc_checker
    import smc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         req_type,
    input  logic [7:0]         task_id,
    input  logic [7:0]         task_prio,
    input  logic [TICKS_W-1:0] wait_ticks,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [COUNT_W-1:0] wr_data,
    input  logic               result_valid,
    input  logic [2:0]         outcome,
    input  logic [7:0]         subject_task,
    input  logic [7:0]         granted_prio,
    input  logic [COUNT_W-1:0] count_now,
    input  logic               last_result,
    output int                 failures,
    output int                 outstanding
);

    typedef struct {
        logic [7:0]         tid;
        logic [7:0]         prio;
        logic [TICKS_W-1:0] ticks;
    } waiter_t;

    typedef struct {
        outcome_t           oc;
        logic [7:0]         tid;
        logic [7:0]         prio;
        logic [COUNT_W-1:0] cnt;
        logic               last;
    } word_t;

    logic [1:0]         kind;
    logic [COUNT_W-1:0] max_cnt;
    logic [COUNT_W-1:0] sem_cnt;
    logic [COUNT_W-1:0] nest;
    logic               own_v;
    logic [7:0]         own_t;
    logic [7:0]         ceil;
    waiter_t            waitq[$];
    word_t              item_words[$];
    word_t              expected_words[$];

    function automatic bit mutex_kind();
        return kind >= KIND_MUTEX;
    endfunction

    function automatic void post(outcome_t oc, logic [7:0] t, logic [7:0] p);
        word_t w;
        w.oc = oc;
        w.tid = t;
        w.prio = p;
        w.cnt = sem_cnt;
        w.last = 1'b0;
        if (item_words.size() < RES_CAP)
            item_words.push_back(w);
    endfunction

    function automatic logic [7:0] hand_to(logic [7:0] t, logic [7:0] p);
        logic [7:0] gp;
        gp = p;
        if (mutex_kind())
        begin
            if (p < ceil)
                ceil = p;
            gp = ceil;
            own_v = 1'b1;
            own_t = t;
            if (kind == KIND_RECURSIVE)
                nest = 16'd1;
        end
        if (sem_cnt > 0)
            sem_cnt = sem_cnt - 16'd1;
        return gp;
    endfunction

    function automatic void wake_best();
        int best;
        waiter_t w;
        logic [7:0] gp;
        best = 0;
        if (waitq.size() == 0 || sem_cnt == 0)
            return;
        for (int i = 1; i < waitq.size(); i++)
            if (waitq[i].prio < waitq[best].prio)
                best = i;
        w = waitq[best];
        waitq.delete(best);
        gp = hand_to(w.tid, w.prio);
        post(OC_WAITER_GRANTED, w.tid, gp);
    endfunction

    function automatic void release_unit();
        own_v = 1'b0;
        nest = '0;
        if (sem_cnt != COUNT_MAX)
            sem_cnt = sem_cnt + 16'd1;
    endfunction

    function automatic void predict_request(logic [1:0] req, logic [7:0] tid,
                                            logic [7:0] prio, logic [TICKS_W-1:0] ticks);
        bit owns;
        int i;
        waiter_t w;
        logic [7:0] gp;
        owns = mutex_kind() && own_v && own_t == tid;
        item_words.delete();
        case (req)
            REQ_TAKE:
            begin
                if (owns)
                begin
                    if (kind == KIND_RECURSIVE)
                    begin
                        if (nest != COUNT_MAX)
                            nest = nest + 16'd1;
                        post(OC_GRANTED, tid, ceil);
                    end
                    else
                        post(OC_REFUSED, tid, prio);
                end
                else if (sem_cnt > 0)
                begin
                    gp = hand_to(tid, prio);
                    post(OC_GRANTED, tid, gp);
                end
                else if (ticks != 0 && waitq.size() < 8)
                begin
                    w.tid = tid;
                    w.prio = prio;
                    w.ticks = ticks;
                    waitq.push_back(w);
                    post(OC_QUEUED, tid, prio);
                end
                else
                    post(OC_REFUSED, tid, prio);
            end
            REQ_GIVE:
            begin
                if (mutex_kind())
                begin
                    if (!owns)
                        post(OC_GIVE_REFUSED, tid, prio);
                    else if (kind == KIND_RECURSIVE && nest > 1)
                    begin
                        nest = nest - 16'd1;
                        post(OC_GIVEN, tid, prio);
                    end
                    else
                    begin
                        release_unit();
                        post(OC_GIVEN, tid, prio);
                        wake_best();
                    end
                end
                else if (sem_cnt >= max_cnt)
                    post(OC_GIVE_REFUSED, tid, prio);
                else
                begin
                    sem_cnt = sem_cnt + 16'd1;
                    post(OC_GIVEN, tid, prio);
                    wake_best();
                end
            end
            REQ_TICK:
            begin
                i = 0;
                while (i < waitq.size())
                begin
                    if (waitq[i].ticks != FOREVER && waitq[i].ticks <= 1)
                    begin
                        if (item_words.size() < RES_CAP)
                        begin
                            w = waitq[i];
                            waitq.delete(i);
                            post(OC_WAITER_EXPIRED, w.tid, w.prio);
                            continue;
                        end
                        waitq[i].ticks = '0;
                    end
                    else if (waitq[i].ticks != FOREVER)
                        waitq[i].ticks = waitq[i].ticks - 32'd1;
                    i++;
                end
            end
            default:
            begin
                i = 0;
                while (i < waitq.size())
                begin
                    if (waitq[i].tid == tid)
                        waitq.delete(i);
                    else
                        i++;
                end
                post(OC_KILL_DONE, tid, prio);
                if (owns)
                begin
                    release_unit();
                    item_words[0].cnt = sem_cnt;
                    wake_best();
                end
            end
        endcase
        if (item_words.size() > 0)
            item_words[item_words.size() - 1].last = 1'b1;
        foreach (item_words[j])
            expected_words.push_back(item_words[j]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t e;
        if (!rst_n)
        begin
            kind = KIND_BINARY;
            max_cnt = 16'd1;
            sem_cnt = 16'd1;
            nest = '0;
            own_v = 1'b0;
            own_t = '0;
            ceil = '1;
            waitq.delete();
            expected_words.delete();
            failures = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_SEM_KIND:
                        kind = wr_data[1:0];
                    REG_MAX_COUNT:
                        max_cnt = wr_data;
                    REG_INITIAL_COUNT:
                    begin
                        sem_cnt = wr_data;
                        if (mutex_kind() && sem_cnt > 1)
                            sem_cnt = 16'd1;
                    end
                    default:
                        ;
                endcase
            end
            if (start && !busy)
                predict_request(req_type, task_id, task_prio, wait_ticks);
            if (result_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word outcome=%0d task=%0d prio=%0d count=%0d",
                             $time, outcome, subject_task, granted_prio, count_now);
                    failures++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (outcome !== e.oc || subject_task !== e.tid || granted_prio !== e.prio
                        || count_now !== e.cnt || last_result !== e.last)
                    begin
                        $display("%0t: mismatch expected oc=%0d task=%0d prio=%0d cnt=%0d last=%0d",
                                 $time, e.oc, e.tid, e.prio, e.cnt, e.last);
                        $display("%0t:          actual   oc=%0d task=%0d prio=%0d cnt=%0d last=%0d",
                                 $time, outcome, subject_task, granted_prio, count_now,
                                 last_result);
                        failures++;
                    end
                end
            end
        end
        outstanding = expected_words.size();
    end

endmodule

// File: bench/tb_semaphore_mutex_ceiling_unit.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the semaphore / mutex ceiling unit: directed and random
// requests over several register settings. Depends on smc_pkg and smc_checker.
module tb_semaphore_mutex_ceiling_unit;
    import smc_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         req_type = REQ_TAKE;
    logic [7:0]         task_id = '0;
    logic [7:0]         task_prio = '0;
    logic [TICKS_W-1:0] wait_ticks = '0;
    logic               wr_en = 1'b0;
    logic [1:0]         wr_index = REG_SEM_KIND;
    logic [COUNT_W-1:0] wr_data = '0;
    logic               result_valid;
    logic [2:0]         outcome;
    logic [7:0]         subject_task;
    logic [7:0]         granted_prio;
    logic [COUNT_W-1:0] count_now;
    logic               last_result;
    int                 failures;
    int                 outstanding;
    int                 sent = 0;
    bit                 calm = 1'b0;

    always #1 clk = ~clk;

    semaphore_mutex_ceiling_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .task_id(task_id), .task_prio(task_prio),
        .wait_ticks(wait_ticks), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .result_valid(result_valid), .outcome(outcome), .subject_task(subject_task),
        .granted_prio(granted_prio), .count_now(count_now), .last_result(last_result)
    );

    smc_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .task_id(task_id), .task_prio(task_prio),
        .wait_ticks(wait_ticks), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .result_valid(result_valid), .outcome(outcome), .subject_task(subject_task),
        .granted_prio(granted_prio), .count_now(count_now), .last_result(last_result),
        .failures(failures), .outstanding(outstanding)
    );

    // hold the request until it is taken; the caller is at a falling edge
    task automatic request(logic [1:0] rt, logic [7:0] tid, logic [7:0] prio,
                           logic [TICKS_W-1:0] ticks);
        bit taken;
        start <= 1'b1;
        req_type <= rt;
        task_id <= tid;
        task_prio <= prio;
        wait_ticks <= ticks;
        do
        begin
            #0.1;
            taken = !busy;
            @(negedge clk);
        end
        while (!taken);
        sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [COUNT_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(negedge clk);
    endtask

    task automatic setup(logic [1:0] kind, logic [COUNT_W-1:0] maxc, logic [COUNT_W-1:0] init);
        write_reg(REG_SEM_KIND, {14'd0, kind});
        write_reg(REG_MAX_COUNT, maxc);
        write_reg(REG_INITIAL_COUNT, init);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [TICKS_W-1:0] pick_ticks();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return FOREVER;
            3:       return $urandom;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic random_burst(int n, int tasks);
        logic [1:0] rt;
        logic [7:0] tid;
        logic [7:0] prio;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            rt = r < 40 ? REQ_TAKE : r < 70 ? REQ_GIVE : r < 90 ? REQ_TICK : REQ_KILL;
            tid = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, tasks));
            prio = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7) * 32);
            request(rt, tid, prio, pick_ticks());
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: binary semaphore
        request(REQ_TAKE, 8'd0, 8'd0, '0);
        request(REQ_TAKE, 8'd1, 8'd255, '0);
        request(REQ_GIVE, 8'd255, 8'd255, '0);
        request(REQ_GIVE, 8'd2, 8'd7, '0);
        random_burst(30, 5);
        drain();

        // plain mutex: retake, foreign give, full table, tick, kill of owner
        setup(KIND_MUTEX, 16'd5, 16'd9);
        write_reg(2'd3, 16'hFFFF);
        wr_en <= 1'b0;
        request(REQ_TAKE, 8'd1, 8'd200, '0);
        request(REQ_TAKE, 8'd1, 8'd200, '0);
        request(REQ_GIVE, 8'd2, 8'd10, '0);
        request(REQ_TAKE, 8'd3, 8'd50, '0);
        for (int i = 0; i < 9; i++)
            request(REQ_TAKE, 8'(4 + i % 3), 8'(100 - i * 10), i == 0 ? FOREVER : 32'(i % 3 + 1));
        request(REQ_TICK, 8'd0, 8'd0, '0);
        request(REQ_KILL, 8'd5, 8'd0, '0);
        request(REQ_KILL, 8'd1, 8'd0, '0);
        request(REQ_TICK, 8'd0, 8'd0, '0);
        request(REQ_TICK, 8'd0, 8'd0, '0);
        random_burst(45, 6);
        drain();

        // recursive mutex with nesting
        setup(KIND_RECURSIVE, 16'd1, 16'd1);
        request(REQ_TAKE, 8'd7, 8'd3, '0);
        request(REQ_TAKE, 8'd7, 8'd3, '0);
        request(REQ_TAKE, 8'd8, 8'd1, 32'd4);
        request(REQ_GIVE, 8'd7, 8'd3, '0);
        request(REQ_GIVE, 8'd7, 8'd3, '0);
        random_burst(50, 6);
        drain();

        setup(KIND_COUNTING, 16'hFFFF, 16'd0);
        random_burst(45, 7);
        drain();

        setup(KIND_COUNTING, 16'd3, 16'd2);
        random_burst(45, 7);
        drain();

        // switch kind in use without reloading the count
        write_reg(REG_INITIAL_COUNT, 16'hFFFF);
        write_reg(REG_SEM_KIND, {14'd0, KIND_BINARY});
        write_reg(REG_MAX_COUNT, 16'd1);
        wr_en <= 1'b0;
        random_burst(30, 5);
        drain();

        setup(KIND_COUNTING, 16'd1, 16'hFFFF);
        random_burst(20, 5);
        drain();

        write_reg(REG_SEM_KIND, {14'd0, KIND_MUTEX});
        wr_en <= 1'b0;
        calm = 1'b1;
        random_burst(45, 5);
        drain();

        $display("Covered %0d requests over binary, counting, mutex and recursive kinds,",
                 sent);
        $display("including full waiter tables, expiries, kills and kind changes in use.");
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Timeout with %0d words outstanding", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: semaphore_mutex_ceiling_unit.f
sv/smc_pkg.sv
sv/smc_cell.sv
sv/semaphore_mutex_ceiling_unit.sv
bench/smc_checker.sv
bench/tb_semaphore_mutex_ceiling_unit.sv
